// ===== src/adm_pkg.sv =====
// Shared types, constants and helpers for the arcade drive mixer.
// Used by arcade_drive_mixer_with_smoothing; no dependencies.
package adm_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int KEEP_SHIFT = 16;
  localparam int SMOOTH_W   = FRAC_BITS + 10;
  localparam int SUM_W      = SMOOTH_W + 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  localparam logic [7:0]  TURN_CENTRE = 8'd100;
  localparam logic [7:0]  DIR_REVERSE = 8'd1;
  localparam logic [7:0]  RUN_GO      = 8'd10;
  localparam logic [5:0]  MOVE_MUL    = 6'd51;
  localparam logic [15:0] RECIP_5     = 16'd52429;

  localparam logic [7:0]  PERIOD_RST  = 8'd10;
  localparam logic [15:0] TIMEOUT_RST = 16'd200;
  localparam logic [15:0] SLOW_RST    = 16'd64225;
  localparam logic [15:0] FAST_RST    = 16'd62259;
  localparam logic [7:0]  BAND_RST    = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_PERIOD = 3'd0,
    REG_LINK_TIMEOUT  = 3'd1,
    REG_SLOW_KEEP     = 3'd2,
    REG_FAST_KEEP     = 3'd3,
    REG_STOP_BAND     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef struct packed {
    logic [7:0] right_reverse_duty;
    logic [7:0] right_forward_duty;
    logic [7:0] left_reverse_duty;
    logic [7:0] left_forward_duty;
    logic signed [8:0] right_speed;
    logic signed [8:0] left_speed;
  } result_t;

  // raw * 255 / 200 = floor(floor(raw * 51 / 8) / 5)
  function automatic logic [8:0] scale_move(input logic [7:0] raw);
    logic [13:0] prod;
    logic [10:0] eighth;
    logic [26:0] recip;
    prod   = 14'(raw) * 14'(MOVE_MUL);
    eighth = prod[13:3];
    recip  = 27'(eighth) * 27'(RECIP_5);
    return recip[26:18];
  endfunction

endpackage

// ===== src/arcade_drive_mixer_with_smoothing.sv =====
// Arcade drive mixer with low-pass smoothing: top level.
// Depends on adm_pkg for constants, register indexes and the move scaler.
//
// Input beats on s_* carry either a joystick packet (s_tuser = 0) or a
// one-millisecond tick (s_tuser = 1). A packet replaces the held
// command and clears since_packet_ms. A tick advances the saturating
// timers; once more than filter_period_ms has passed since the last
// update, it runs one filter update and yields one result beat on m_*
// with both motor speeds and their forward and reverse duties. Other
// beats yield nothing. A tick beat that causes a result passes the input
// register, the filter state register and then the result register.
// Throughput: one beat per cycle while m_tready is high; the input
// register keeps taking a beat while a result waits to be taken.
// When m_tready stays low the result and the pending update hold and
// s_tready drops once the input register fills.
// cfg_we writes register cfg_index with cfg_data; unknown indexes are
// dropped. rst (synchronous) restores the register defaults, the
// centred held command, cleared timers and cleared filter memory.
module arcade_drive_mixer_with_smoothing (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // raw_move, raw_turn, direction_code, run_code, packet_valid, link_up, zero pad
  input  logic [adm_pkg::IN_DATA_W-1:0] s_tdata,
  // operation
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // left_speed, right_speed, left_forward_duty, left_reverse_duty,
  // right_forward_duty, right_reverse_duty, zero pad
  output logic [adm_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [adm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW   = adm_pkg::SMOOTH_W;
  localparam int SUMW = adm_pkg::SUM_W;
  localparam int FB   = adm_pkg::FRAC_BITS;
  localparam int KS   = adm_pkg::KEEP_SHIFT;
  localparam logic signed [SW:0] LIM = (SW+1)'(255);

  function automatic logic signed [SW-1:0] lowpass(input logic signed [SW-1:0] prev,
                                                   input logic signed [9:0] x,
                                                   input logic [15:0] keep);
    logic signed [16:0]     keep_s;
    logic signed [17:0]     gain_s;
    logic signed [SUMW-1:0] a;
    logic signed [SUMW-1:0] b;
    logic signed [SUMW-1:0] sum;
    logic signed [SUMW-1:0] q;
    keep_s = signed'({1'b0, keep});
    gain_s = signed'(18'd65536 - {2'b00, keep});
    a      = SUMW'(keep_s) * SUMW'(prev);
    b      = (SUMW'(gain_s) * SUMW'(x)) <<< FB;
    sum    = a + b;
    q      = sum >>> KS;
    if (sum[SUMW-1] && (sum[KS-1:0] != '0)) begin
      q = q + SUMW'(1);
    end
    return q[SW-1:0];
  endfunction

  function automatic logic signed [8:0] mix_clamp(input logic signed [SW:0] v);
    logic signed [SW:0] q;
    q = v >>> FB;
    if (v[SW] && (v[FB-1:0] != '0)) begin
      q = q + (SW+1)'(1);
    end
    if (q > LIM) begin
      return 9'sd255;
    end
    if (q < -LIM) begin
      return -9'sd255;
    end
    return q[8:0];
  endfunction

  // configuration
  logic [7:0]  filter_period_ms;
  logic [15:0] link_timeout_ms;
  logic [15:0] slow_keep;
  logic [15:0] fast_keep;
  logic [7:0]  stop_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_period_ms <= adm_pkg::PERIOD_RST;
      link_timeout_ms  <= adm_pkg::TIMEOUT_RST;
      slow_keep        <= adm_pkg::SLOW_RST;
      fast_keep        <= adm_pkg::FAST_RST;
      stop_band        <= adm_pkg::BAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        adm_pkg::REG_FILTER_PERIOD: filter_period_ms <= cfg_data[7:0];
        adm_pkg::REG_LINK_TIMEOUT:  link_timeout_ms  <= cfg_data;
        adm_pkg::REG_SLOW_KEEP:     slow_keep        <= cfg_data;
        adm_pkg::REG_FAST_KEEP:     fast_keep        <= cfg_data;
        adm_pkg::REG_STOP_BAND:     stop_band        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_move;
  logic [7:0] s1_turn;
  logic [7:0] s1_dir;
  logic [7:0] s1_run;
  logic       s1_pkt_ok;
  logic       s1_link_up;

  logic pend;
  logic out_free;
  logic s1_go;
  logic upd_go;

  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && (!pend || out_free);
  assign s_tready = !s1_valid || !pend || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_op      <= s_tuser;
      s1_move    <= s_tdata[7:0];
      s1_turn    <= s_tdata[15:8];
      s1_dir     <= s_tdata[23:16];
      s1_run     <= s_tdata[31:24];
      s1_pkt_ok  <= s_tdata[32];
      s1_link_up <= s_tdata[33];
    end
  end

  // held command, timers and filter memory
  logic [8:0]  held_scaled;
  logic [7:0]  held_turn;
  logic        held_reverse;
  logic        held_go;
  logic        held_valid;
  logic [15:0] since_packet_ms;
  logic [7:0]  since_update_ms;
  logic signed [SW-1:0] smooth_move;
  logic signed [SW-1:0] smooth_turn;

  logic [15:0] since_packet_next;
  logic [7:0]  since_update_next;
  logic        is_tick;
  logic        kill;
  logic signed [9:0] mv_base;
  logic signed [9:0] mv_dir;
  logic signed [9:0] tn_base;
  logic signed [9:0] mv;
  logic signed [9:0] tn;
  logic [9:0]  amv;
  logic [15:0] keep;
  logic signed [SW-1:0] prev_move;
  logic signed [SW-1:0] prev_turn;
  logic signed [SW-1:0] smooth_move_next;
  logic signed [SW-1:0] smooth_turn_next;

  always_comb begin
    is_tick = (s1_op == adm_pkg::OP_TICK);
    since_packet_next = (since_packet_ms == '1) ? since_packet_ms : since_packet_ms + 16'd1;
    since_update_next = (since_update_ms == '1) ? since_update_ms : since_update_ms + 8'd1;
    upd_go  = s1_go && is_tick && (since_update_next > filter_period_ms);
    kill    = !s1_link_up || !held_go;
    mv_base = held_valid ? signed'({1'b0, held_scaled}) : '0;
    mv_dir  = held_reverse ? -mv_base : mv_base;
    tn_base = held_valid ? signed'(10'({2'b00, held_turn} - {2'b00, adm_pkg::TURN_CENTRE})) : '0;
    if (kill || (since_packet_next > link_timeout_ms)) begin
      mv = '0;
      tn = '0;
    end else begin
      mv = mv_dir;
      tn = tn_base;
    end
    amv  = mv[9] ? 10'(-mv) : 10'(mv);
    keep = ((amv <= {2'b00, stop_band}) && (tn == '0)) ? fast_keep : slow_keep;
    prev_move = kill ? '0 : smooth_move;
    prev_turn = kill ? '0 : smooth_turn;
    smooth_move_next = lowpass(prev_move, mv, keep);
    smooth_turn_next = lowpass(prev_turn, tn, keep);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_scaled     <= '0;
      held_turn       <= adm_pkg::TURN_CENTRE;
      held_reverse    <= 1'b0;
      held_go         <= 1'b0;
      held_valid      <= 1'b0;
      since_packet_ms <= '0;
      since_update_ms <= '0;
      smooth_move     <= '0;
      smooth_turn     <= '0;
    end else if (s1_go) begin
      if (!is_tick) begin
        held_scaled     <= adm_pkg::scale_move(s1_move);
        held_turn       <= s1_turn;
        held_reverse    <= (s1_dir == adm_pkg::DIR_REVERSE);
        held_go         <= (s1_run == adm_pkg::RUN_GO);
        held_valid      <= s1_pkt_ok;
        since_packet_ms <= '0;
      end else begin
        since_packet_ms <= since_packet_next;
        if (upd_go) begin
          since_update_ms <= '0;
          smooth_move     <= smooth_move_next;
          smooth_turn     <= smooth_turn_next;
        end else begin
          since_update_ms <= since_update_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (upd_go) begin
      pend <= 1'b1;
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  // mix and result register
  logic signed [8:0] left_mix;
  logic signed [8:0] right_mix;
  adm_pkg::result_t  res_next;
  adm_pkg::result_t  res;

  always_comb begin
    left_mix  = mix_clamp((SW+1)'(smooth_move) - (SW+1)'(smooth_turn));
    right_mix = mix_clamp((SW+1)'(smooth_move) + (SW+1)'(smooth_turn));
    res_next.left_speed         = left_mix;
    res_next.right_speed        = right_mix;
    res_next.left_forward_duty  = (left_mix > 0) ? left_mix[7:0] : '0;
    res_next.left_reverse_duty  = (left_mix > 0) ? '0 : 8'(-left_mix);
    res_next.right_forward_duty = (right_mix > 0) ? right_mix[7:0] : '0;
    res_next.right_reverse_duty = (right_mix > 0) ? '0 : 8'(-right_mix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      res <= res_next;
    end
  end

  assign m_tdata = {6'b0, res};

  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    pend && !out_free |=> pend)
    else $error("pending update lost under stall");

  a_timer_clears: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> since_update_ms == '0)
    else $error("update timer not cleared");

  a_kill_clears: assert property (@(posedge clk) disable iff (rst)
    upd_go && kill |=> smooth_move == '0 && smooth_turn == '0)
    else $error("filter memory not cleared on stop");

  a_duty_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.left_forward_duty == '0 || res.left_reverse_duty == '0) &&
                 (res.right_forward_duty == '0 || res.right_reverse_duty == '0))
    else $error("forward and reverse duty both driven");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid)
    else $error("stalled input beat dropped");

endmodule
